// ===== hdl/gif_lzw_pixel_decoder_macros.svh =====
// Assertion helpers used by the checker file
`ifndef GIF_LZW_PIXEL_DECODER_MACROS_SVH
`define GIF_LZW_PIXEL_DECODER_MACROS_SVH

// Clocked check, quiet while reset is high
`define GLPD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that something never happens outside reset
`define GLPD_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== hdl/glpd_pkg.sv =====
package glpd_pkg;

   localparam int COUNT_W = 9;

   localparam logic REQ_BYTE = 1'b0;
   localparam logic REQ_PULL = 1'b1;

   localparam logic [2:0] CSR_MIN_CODE_SIZE     = 3'd0;
   localparam logic [2:0] CSR_SCREEN_WIDTH      = 3'd1;
   localparam logic [2:0] CSR_FRAME_LEFT        = 3'd2;
   localparam logic [2:0] CSR_FRAME_TOP         = 3'd3;
   localparam logic [2:0] CSR_FRAME_WIDTH       = 3'd4;
   localparam logic [2:0] CSR_FRAME_HEIGHT      = 3'd5;
   localparam logic [2:0] CSR_INTERLACED        = 3'd6;
   localparam logic [2:0] CSR_TRANSPARENT_INDEX = 3'd7;

   typedef enum logic [1:0] {
      PH_START,
      PH_RUN,
      PH_DRAIN,
      PH_DONE
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UNPACK,
      ST_TAKE,
      ST_LEN_RD,
      ST_LEN_USE,
      ST_WALK_RD,
      ST_WALK_USE,
      ST_DIVIDE,
      ST_MAP,
      ST_ADDR,
      ST_COMMIT,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic byte_in;
      logic unpack_step;
      logic take;
      logic rd_walk;
      logic len_use;
      logic walk_use;
      logic map;
      logic addr;
      logic commit;
      logic load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic byte_unpack;
      logic walk_active;
      logic unpack_go;
      logic code_ready;
      logic take_len;
      logic div_busy;
   } dp_status_type;

endpackage

// ===== hdl/glpd_div.sv =====
module glpd_div
   import glpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] dividend,
   input  logic [7:0]  divisor,
   output logic        busy,
   output logic [15:0] quotient,
   output logic [7:0]  remainder
);

   logic        busy_ff, busy_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [15:0] quo_ff, quo_in;
   logic [8:0]  rem_ff, rem_in;
   logic [8:0]  rem_shift;
   logic [7:0]  dvs_ff, dvs_in;

   // restoring divider, one quotient bit per cycle
   always_comb begin
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      rem_shift = {rem_ff[7:0], quo_ff[15]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 4'd15;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[14:0], 1'b0};
         if (rem_shift >= {1'b0, dvs_ff}) begin
            rem_in    = rem_shift - {1'b0, dvs_ff};
            quo_in[0] = 1'b1;
         end else begin
            rem_in = rem_shift;
         end
         if (cnt_ff == 4'd0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[7:0];

endmodule

// ===== hdl/glpd_dpath.sv =====
module glpd_dpath
   import glpd_pkg::*;
#(
   parameter int TABLE_ENTRIES = 256
)
(
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   input  logic [7:0]    req_data_byte,
   input  logic          csr_valid,
   input  logic [2:0]    csr_index,
   input  logic [7:0]    csr_data,
   output logic          rsp_write_valid,
   output logic [15:0]   rsp_pixel_address,
   output logic [7:0]    rsp_color_index,
   output logic          rsp_wants_byte,
   output logic          rsp_image_done
);

   localparam int AW = $clog2(TABLE_ENTRIES);
   localparam logic [COUNT_W-1:0] TE = COUNT_W'(TABLE_ENTRIES);

   // configuration
   logic [2:0] msz_ff;
   logic [7:0] sw_ff, left_ff, top_ff, fw_ff, fh_ff, transp_ff;
   logic       intl_ff;

   // decoder state
   phase_type          phase_ff, phase_in;
   logic [COUNT_W-1:0] ec_ff, ec_in;
   logic [3:0]         cw_ff, cw_in;
   logic [2:0]         bitoff_ff, bitoff_in;
   logic [7:0]         cur_ff, cur_in;
   logic [7:0]         sbl_ff, sbl_in;
   logic [7:0]         acc_ff, acc_in;
   logic [3:0]         accb_ff, accb_in;
   logic               full_ff, full_in, grow_ff, grow_in;
   logic [8:0]         prevlen_ff, prevlen_in;
   logic [7:0]         lfc_ff, lfc_in;
   logic [15:0]        poff_ff, poff_in;
   logic [7:0]         walk_ff, walk_in;
   logic               wact_ff, wact_in, live_ff, live_in;
   logic               fix_ff, fix_in, fresh_ff, fresh_in;
   logic [7:0]         last_ff, last_in, code_ff, code_in;

   // pixel work registers
   logic        root_ff, root_in;
   logic [7:0]  color_ff, color_in, next_ff, next_in;
   logic [15:0] row_ff, row_in, addr_ff, addr_in;
   logic        pix_wv_ff, pix_wv_in;
   logic [15:0] pix_addr_ff, pix_addr_in;
   logic [7:0]  pix_color_ff, pix_color_in;

   // code table
   logic [7:0]  prefix_mem [TABLE_ENTRIES];
   logic [7:0]  suffix_mem [TABLE_ENTRIES];
   logic [8:0]  length_mem [TABLE_ENTRIES];
   logic        valid_ff   [TABLE_ENTRIES];
   logic [AW-1:0] rd_addr, wr_addr;
   logic        we_full, we_suffix;
   logic [7:0]  wr_prefix, wr_suffix;
   logic [8:0]  wr_length;
   logic [7:0]  rd_pre_ff, rd_suf_ff;
   logic [8:0]  rd_len_ff;
   logic        rd_val_ff;

   // derived
   logic [2:0]         eff_min;
   logic [COUNT_W-1:0] clr9, rst_ec;
   logic [3:0]         rst_cw;
   logic               rst_full;

   // unpack step
   logic [3:0]  u_w, u_avail, u_need, u_n, u_boff, u_accb;
   logic [7:0]  u_bits, u_acc, u_mask;
   logic        u_live, u_ready;

   // code intake
   logic [COUNT_W-1:0] c9, t_ec0, t_ec1;
   logic [3:0]  t_cw0, t_cw2;
   logic        t_full0, t_full1, t_grow0, t_grow1, t_fix0, t_fresh0;
   logic        is_clr, is_stop, t_add, t_ok;

   // walk
   logic        w_root;
   logic [8:0]  w_len;
   logic [15:0] w_p;
   logic [7:0]  fw_eff, fh_eff;
   logic        div_busy;
   logic [15:0] div_quo;
   logic [7:0]  div_rem;

   // interlace map
   logic [15:0] m_n1, m_n2, m_n3, m_y1, m_y2, m_row;

   assign eff_min  = (msz_ff < 3'd2) ? 3'd2 : msz_ff;
   assign clr9     = COUNT_W'(1) << eff_min;
   assign rst_ec   = clr9 + COUNT_W'(2);
   assign rst_cw   = {1'b0, eff_min} + 4'd1;
   assign rst_full = rst_ec >= TE;
   assign fw_eff   = (fw_ff == 8'd0) ? 8'd1 : fw_ff;
   assign fh_eff   = (fh_ff == 8'd0) ? 8'd1 : fh_ff;

   // one step of bit unpacking
   always_comb begin
      u_w     = (phase_ff == PH_START) ? rst_cw : cw_ff;
      u_avail = 4'd8 - {1'b0, bitoff_ff};
      u_need  = u_w - accb_ff;
      u_n     = (u_need < u_avail) ? u_need : u_avail;
      u_acc   = acc_ff;
      u_accb  = accb_ff;
      u_boff  = {1'b0, bitoff_ff};
      u_live  = live_ff;
      u_bits  = '0;
      if (accb_ff < u_w) begin
         u_bits = (cur_ff >> bitoff_ff) & 8'((9'd1 << u_n) - 9'd1);
         u_acc  = acc_ff | 8'(u_bits << accb_ff);
         u_accb = accb_ff + u_n;
         u_boff = {1'b0, bitoff_ff} + u_n;
         if (u_boff >= 4'd8) begin
            u_boff = 4'd0;
            u_live = 1'b0;
         end
      end
      u_ready = u_accb >= u_w;
      u_mask  = 8'((9'd1 << u_w) - 9'd1);
   end

   // code intake: restart, add entry, grow, range check
   always_comb begin
      c9       = COUNT_W'(code_ff);
      t_ec0    = (phase_ff == PH_START) ? rst_ec : ec_ff;
      t_cw0    = (phase_ff == PH_START) ? rst_cw : cw_ff;
      t_full0  = (phase_ff == PH_START) ? rst_full : full_ff;
      t_grow0  = (phase_ff == PH_START) ? 1'b0 : grow_ff;
      t_fix0   = (phase_ff == PH_START) ? 1'b0 : fix_ff;
      t_fresh0 = (phase_ff == PH_START) ? 1'b1 : fresh_ff;
      is_clr   = c9 == clr9;
      is_stop  = c9 == clr9 + COUNT_W'(1);
      t_add    = !is_clr && !is_stop && !t_fresh0 && !t_full0;
      t_ec1    = t_add ? t_ec0 + COUNT_W'(1) : t_ec0;
      t_grow1  = t_grow0;
      t_full1  = t_full0;
      if (t_add && ((t_ec1 & (t_ec1 - COUNT_W'(1))) == '0)) begin
         t_grow1 = 1'b1;
      end
      if (t_add && t_ec1 >= TE) begin
         t_full1 = 1'b1;
         t_grow1 = 1'b0;
      end
      t_cw2 = t_cw0;
      if (t_grow1 && t_cw0 < 4'd8) begin
         t_cw2 = t_cw0 + 4'd1;
      end
      t_ok = (c9 < clr9) ||
             (c9 >= clr9 + COUNT_W'(2) && c9 < t_ec1 && c9 < TE);
   end

   // entry at the head of the walk
   always_comb begin
      w_root = (COUNT_W'(walk_ff) < clr9) || (COUNT_W'(walk_ff) >= TE);
      w_len  = (w_root || !rd_val_ff) ? 9'd1 : rd_len_ff;
      w_p    = poff_ff + 16'(w_len) - 16'd1;
   end

   // row map: straight rows, or the four-pass interlace map when interlaced
   always_comb begin
      m_n1 = 16'(({1'b0, fh_eff} + 9'd7) >> 3);
      m_n2 = 16'(({1'b0, fh_eff} + 9'd3) >> 3);
      m_n3 = 16'(({1'b0, fh_eff} + 9'd1) >> 2);
      m_y1 = div_quo - m_n1;
      m_y2 = m_y1 - m_n2;
      if (!intl_ff) begin
         m_row = div_quo;
      end else if (div_quo < m_n1) begin
         m_row = div_quo << 3;
      end else if (m_y1 < m_n2) begin
         m_row = (m_y1 << 3) + 16'd4;
      end else if (m_y2 < m_n3) begin
         m_row = (m_y2 << 2) + 16'd2;
      end else begin
         m_row = ((m_y2 - m_n3) << 1) + 16'd1;
      end
   end

   glpd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.walk_use),
      .dividend  (w_p),
      .divisor   (fw_eff),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // next-state of the datapath
   always_comb begin
      phase_in = phase_ff;   ec_in = ec_ff;       cw_in = cw_ff;
      bitoff_in = bitoff_ff; cur_in = cur_ff;     sbl_in = sbl_ff;
      acc_in = acc_ff;       accb_in = accb_ff;   full_in = full_ff;
      grow_in = grow_ff;     prevlen_in = prevlen_ff;
      lfc_in = lfc_ff;       poff_in = poff_ff;   walk_in = walk_ff;
      wact_in = wact_ff;     live_in = live_ff;   fix_in = fix_ff;
      fresh_in = fresh_ff;   last_in = last_ff;   code_in = code_ff;
      root_in = root_ff;     color_in = color_ff; next_in = next_ff;
      row_in = row_ff;       addr_in = addr_ff;
      pix_wv_in = pix_wv_ff; pix_addr_in = pix_addr_ff;
      pix_color_in = pix_color_ff;
      we_full = 1'b0;        we_suffix = 1'b0;
      wr_addr = t_ec0[AW-1:0];
      wr_prefix = last_ff;   wr_suffix = lfc_ff;
      wr_length = prevlen_ff + 9'd1;

      if (cmd.accept) begin
         pix_wv_in    = 1'b0;
         pix_addr_in  = '0;
         pix_color_in = '0;
      end

      if (cmd.byte_in) begin
         if (phase_ff == PH_DRAIN) begin
            if (sbl_ff != 8'd0) begin
               sbl_in = sbl_ff - 8'd1;
            end else if (req_data_byte == 8'd0) begin
               phase_in = PH_DONE;
            end else begin
               sbl_in = req_data_byte;
            end
         end else if (phase_ff != PH_DONE && !wact_ff) begin
            if (sbl_ff == 8'd0) begin
               sbl_in = req_data_byte;
            end else begin
               sbl_in    = sbl_ff - 8'd1;
               cur_in    = req_data_byte;
               bitoff_in = '0;
               live_in   = 1'b1;
            end
         end
      end

      if (cmd.unpack_step) begin
         bitoff_in = u_boff[2:0];
         live_in   = u_live;
         if (u_ready) begin
            code_in = u_acc & u_mask;
            acc_in  = '0;
            accb_in = '0;
         end else begin
            acc_in  = u_acc;
            accb_in = u_accb;
         end
      end

      if (cmd.take) begin
         if (is_clr) begin
            phase_in = PH_RUN;  ec_in = rst_ec;   cw_in = rst_cw;
            full_in = rst_full; grow_in = 1'b0;   fix_in = 1'b0;
            fresh_in = 1'b1;
         end else if (is_stop) begin
            phase_in = PH_DRAIN; live_in = 1'b0;
            ec_in = t_ec0;     cw_in = t_cw0;     full_in = t_full0;
            grow_in = t_grow0; fix_in = t_fix0;   fresh_in = t_fresh0;
         end else begin
            we_full = t_add;
            ec_in   = t_ec1;
            cw_in   = t_cw2;
            full_in = t_full1;
            grow_in = 1'b0;
            fix_in  = t_add ? 1'b1 : t_fix0;
            if (t_ok) begin
               phase_in = PH_RUN;
               last_in  = code_ff;
               walk_in  = code_ff;
               wact_in  = 1'b1;
               fresh_in = 1'b0;
            end else begin
               phase_in = PH_DRAIN;
               live_in  = 1'b0;
               fresh_in = t_fresh0;
            end
         end
      end

      if (cmd.len_use) begin
         prevlen_in = (COUNT_W'(last_ff) < clr9 || !rd_val_ff) ? 9'd1 : rd_len_ff;
      end

      if (cmd.walk_use) begin
         root_in  = w_root;
         color_in = (w_root || !rd_val_ff) ? walk_ff : rd_suf_ff;
         next_in  = rd_val_ff ? rd_pre_ff : 8'd0;
      end

      if (cmd.map) begin
         row_in = m_row;
      end

      if (cmd.addr) begin
         addr_in = 16'((16'(top_ff) + row_ff) * sw_ff) + 16'(left_ff) + 16'(div_rem);
      end

      if (cmd.commit) begin
         if (color_ff != transp_ff) begin
            pix_wv_in    = 1'b1;
            pix_addr_in  = addr_ff;
            pix_color_in = color_ff;
         end
         if (root_ff) begin
            wact_in = 1'b0;
            lfc_in  = walk_ff;
            if (fix_ff) begin
               // last added entry gets its real final character
               we_suffix = 1'b1;
               wr_addr   = AW'(ec_ff - COUNT_W'(1));
               wr_suffix = walk_ff;
               fix_in    = 1'b0;
            end
            poff_in = poff_ff + 16'(prevlen_ff);
         end else begin
            walk_in = next_ff;
         end
      end
   end

   assign rd_addr = cmd.rd_walk ? walk_ff[AW-1:0] : last_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (we_full) begin
         prefix_mem[wr_addr] <= wr_prefix;
         length_mem[wr_addr] <= wr_length;
      end
      if (we_full || we_suffix) begin
         suffix_mem[wr_addr] <= wr_suffix;
      end
      rd_pre_ff <= prefix_mem[rd_addr];
      rd_suf_ff <= suffix_mem[rd_addr];
      rd_len_ff <= length_mem[rd_addr];
      rd_val_ff <= valid_ff[rd_addr];
   end

   // written entries; an unwritten one reads as its reset value
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (we_full) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         msz_ff <= 3'd2;  sw_ff <= 8'd1;  left_ff <= '0;  top_ff <= '0;
         fw_ff <= 8'd1;   fh_ff <= 8'd1;  intl_ff <= 1'b0; transp_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_CODE_SIZE:     msz_ff    <= csr_data[2:0];
            CSR_SCREEN_WIDTH:      sw_ff     <= csr_data;
            CSR_FRAME_LEFT:        left_ff   <= csr_data;
            CSR_FRAME_TOP:         top_ff    <= csr_data;
            CSR_FRAME_WIDTH:       fw_ff     <= csr_data;
            CSR_FRAME_HEIGHT:      fh_ff     <= csr_data;
            CSR_INTERLACED:        intl_ff   <= csr_data[0];
            CSR_TRANSPARENT_INDEX: transp_ff <= csr_data;
            default:               msz_ff    <= msz_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;  ec_ff <= COUNT_W'(6);  cw_ff <= 4'd3;
         bitoff_ff <= '0;       cur_ff <= '0;          sbl_ff <= '0;
         acc_ff <= '0;          accb_ff <= '0;         full_ff <= 1'b0;
         grow_ff <= 1'b0;       prevlen_ff <= '0;      lfc_ff <= '0;
         poff_ff <= '0;         walk_ff <= '0;         wact_ff <= 1'b0;
         live_ff <= 1'b0;       fix_ff <= 1'b0;        fresh_ff <= 1'b1;
         last_ff <= '0;
      end else begin
         phase_ff <= phase_in;  ec_ff <= ec_in;        cw_ff <= cw_in;
         bitoff_ff <= bitoff_in; cur_ff <= cur_in;     sbl_ff <= sbl_in;
         acc_ff <= acc_in;      accb_ff <= accb_in;    full_ff <= full_in;
         grow_ff <= grow_in;    prevlen_ff <= prevlen_in; lfc_ff <= lfc_in;
         poff_ff <= poff_in;    walk_ff <= walk_in;    wact_ff <= wact_in;
         live_ff <= live_in;    fix_ff <= fix_in;      fresh_ff <= fresh_in;
         last_ff <= last_in;
      end
      code_ff <= code_in;    root_ff <= root_in;   color_ff <= color_in;
      next_ff <= next_in;    row_ff <= row_in;     addr_ff <= addr_in;
      pix_wv_ff <= pix_wv_in; pix_addr_ff <= pix_addr_in;
      pix_color_ff <= pix_color_in;
   end

   // result word
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_write_valid   <= pix_wv_ff;
         rsp_pixel_address <= pix_addr_ff;
         rsp_color_index   <= pix_color_ff;
         rsp_wants_byte    <= !wact_ff && phase_ff != PH_DONE;
         rsp_image_done    <= phase_ff == PH_DONE;
      end
   end

   assign status.byte_unpack = phase_ff != PH_DRAIN && phase_ff != PH_DONE &&
                               !wact_ff && sbl_ff != 8'd0;
   assign status.walk_active = wact_ff;
   assign status.unpack_go   = live_ff && !wact_ff &&
                               (phase_ff == PH_START || phase_ff == PH_RUN);
   assign status.code_ready  = u_ready;
   assign status.take_len    = !is_clr && !is_stop && t_ok;
   assign status.div_busy    = div_busy;

endmodule

// ===== hdl/glpd_ctrl.sv =====
module glpd_ctrl
   import glpd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_type,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = state_ff != ST_IDLE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (req_type == REQ_BYTE) begin
                  cmd.byte_in = 1'b1;
                  state_in    = status.byte_unpack ? ST_UNPACK : ST_FINISH;
               end else begin
                  state_in = status.walk_active ? ST_WALK_RD : ST_FINISH;
               end
            end
         end
         ST_UNPACK: begin
            if (!status.unpack_go) begin
               state_in = ST_FINISH;
            end else begin
               cmd.unpack_step = 1'b1;
               if (status.code_ready) begin
                  state_in = ST_TAKE;
               end
            end
         end
         ST_TAKE: begin
            cmd.take = 1'b1;
            state_in = status.take_len ? ST_LEN_RD : ST_UNPACK;
         end
         ST_LEN_RD:  state_in = ST_LEN_USE;
         ST_LEN_USE: begin
            cmd.len_use = 1'b1;
            state_in    = ST_UNPACK;
         end
         ST_WALK_RD: begin
            cmd.rd_walk = 1'b1;
            state_in    = ST_WALK_USE;
         end
         ST_WALK_USE: begin
            cmd.walk_use = 1'b1;
            state_in     = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (!status.div_busy) begin
               state_in = ST_MAP;
            end
         end
         ST_MAP: begin
            cmd.map  = 1'b1;
            state_in = ST_ADDR;
         end
         ST_ADDR: begin
            cmd.addr = 1'b1;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            // a finished string resumes unpacking of the held byte
            cmd.commit = 1'b1;
            state_in   = ST_UNPACK;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hdl/gif_lzw_pixel_decoder.sv =====
// GIF LZW pixel decoder. Feed the image data bytes, sub-block length bytes
// included, as req_type 0 and pull pixels with req_type 1 while wants_byte
// is low; each word in gives one result word. A data byte goes through its
// unpack steps and, per completed code, a table write, then a registered
// table read for the string length. A pixel pull runs the 16-step
// shift-subtract divider that splits the pixel offset into row and column,
// followed by the interlace map and the address multiply; the last pixel
// of a string also resumes unpacking of the held byte and takes in its
// codes. A stalled output holds back the next result. The code table has
// per-entry valid bits cleared at reset, so there is no clearing pass.
// Results wait in an output register while the next word is accepted.
// Configuration writes are always ready.
module gif_lzw_pixel_decoder
   import glpd_pkg::*;
#(
   parameter int TABLE_ENTRIES = 256
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_type,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_write_valid,
   output logic [15:0] rsp_pixel_address,
   output logic [7:0]  rsp_color_index,
   output logic        rsp_wants_byte,
   output logic        rsp_image_done,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   glpd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   glpd_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_data_byte     (req_data_byte),
      .csr_valid         (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_write_valid   (rsp_write_valid),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_color_index   (rsp_color_index),
      .rsp_wants_byte    (rsp_wants_byte),
      .rsp_image_done    (rsp_image_done)
   );

endmodule

// ===== hdl/glpd_checker.sv =====
`include "gif_lzw_pixel_decoder_macros.svh"

module glpd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_write_valid,
   input logic [15:0] rsp_pixel_address,
   input logic [7:0]  rsp_color_index,
   input logic        rsp_wants_byte,
   input logic        rsp_image_done
);

   // a result held back stays offered
   `GLPD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid, "result dropped while stalled")

   // a word without a pixel write carries zero address and color
   `GLPD_ASSERT(a_empty_zero, clock, reset, rsp_valid && !rsp_write_valid |-> rsp_pixel_address == 16'd0 && rsp_color_index == 8'd0, "empty result with payload")

   // a finished image never asks for more bytes
   `GLPD_NEVER(a_done_no_want, clock, reset, rsp_valid && rsp_wants_byte && rsp_image_done, "wants byte after done")

   // done stays once reported
   `GLPD_ASSERT(a_done_sticky, clock, reset, rsp_valid && rsp_image_done |=> rsp_image_done, "image done cleared")

endmodule

bind gif_lzw_pixel_decoder glpd_checker u_glpd_checker (.*);
